// ===== rtl/mpbd_pkg.sv =====
// shared types and constants for the masked packed base distance core
package mpbd_pkg;

  localparam int unsigned TOTAL_W = 32;
  localparam int unsigned WORD_W  = 64;
  localparam int unsigned MASK_W  = 32;
  localparam int unsigned BASE_W  = 2;

  typedef struct packed {
    logic incl;
    logic diff;
  } lane_flags_t;

endpackage

// ===== rtl/mpbd_lane.sv =====
// one lane: gates a single base pair by its mask bit and flags a difference
module mpbd_lane (
  input  logic [mpbd_pkg::BASE_W-1:0] base_a_i,
  input  logic [mpbd_pkg::BASE_W-1:0] base_b_i,
  input  logic                        include_i,
  output mpbd_pkg::lane_flags_t       flags_o
);

  assign flags_o.incl = include_i;
  assign flags_o.diff = include_i & (base_a_i != base_b_i);

endmodule

// ===== rtl/mpbd_merge.sv =====
// merges lane flags: popcounts, saturating totals and the result register
module mpbd_merge #(
  parameter int unsigned LANES = 32
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  mpbd_pkg::lane_flags_t [LANES-1:0]     flags_i,
  input  logic                                  in_valid_i,
  input  logic                                  last_i,
  output logic                                  in_ready_o,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [mpbd_pkg::TOTAL_W-1:0]          mismatch_count_o,
  output logic [mpbd_pkg::TOTAL_W-1:0]          compared_count_o
);

  localparam int unsigned GRP   = 8;
  localparam int unsigned NGRP  = (LANES + GRP - 1) / GRP;
  localparam int unsigned GRP_W = $clog2(GRP + 1);
  localparam int unsigned CNT_W = $clog2(LANES + 1);

  function automatic logic [mpbd_pkg::TOTAL_W-1:0] sat_add(
    input logic [mpbd_pkg::TOTAL_W-1:0] acc,
    input logic [mpbd_pkg::TOTAL_W-1:0] inc
  );
    logic [mpbd_pkg::TOTAL_W:0] sum;
    sum = {1'b0, acc} + {1'b0, inc};
    return sum[mpbd_pkg::TOTAL_W] ? '1 : sum[mpbd_pkg::TOTAL_W-1:0];
  endfunction

  logic [NGRP-1:0][GRP_W-1:0]     grp_incl, grp_diff;
  logic [CNT_W-1:0]               incl_cnt, diff_cnt;
  logic [mpbd_pkg::TOTAL_W-1:0]   mis_total_q, mis_total_d;
  logic [mpbd_pkg::TOTAL_W-1:0]   cmp_total_q, cmp_total_d;
  logic [mpbd_pkg::TOTAL_W-1:0]   mis_sum, cmp_sum;
  logic [mpbd_pkg::TOTAL_W-1:0]   mis_out_q, mis_out_d, cmp_out_q, cmp_out_d;
  logic                           out_valid_q, out_valid_d;
  logic                           accept;

  // popcount in groups of eight lanes, then add the group counts
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_incl[g] = '0;
      grp_diff[g] = '0;
      for (int i = 0; i < GRP; i++) begin
        if (g * GRP + i < LANES) begin
          grp_incl[g] = grp_incl[g] + GRP_W'(flags_i[g * GRP + i].incl);
          grp_diff[g] = grp_diff[g] + GRP_W'(flags_i[g * GRP + i].diff);
        end
      end
    end
    incl_cnt = '0;
    diff_cnt = '0;
    for (int g = 0; g < NGRP; g++) begin
      incl_cnt = incl_cnt + CNT_W'(grp_incl[g]);
      diff_cnt = diff_cnt + CNT_W'(grp_diff[g]);
    end
  end

  assign in_ready_o = ~out_valid_q | out_ready_i;
  assign accept     = in_valid_i & in_ready_o;

  assign mis_sum = sat_add(mis_total_q, mpbd_pkg::TOTAL_W'(diff_cnt));
  assign cmp_sum = sat_add(cmp_total_q, mpbd_pkg::TOTAL_W'(incl_cnt));

  always_comb begin
    mis_total_d = mis_total_q;
    cmp_total_d = cmp_total_q;
    mis_out_d   = mis_out_q;
    cmp_out_d   = cmp_out_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    if (accept) begin
      if (last_i) begin
        mis_out_d   = mis_sum;
        cmp_out_d   = cmp_sum;
        out_valid_d = 1'b1;
        mis_total_d = '0;
        cmp_total_d = '0;
      end else begin
        mis_total_d = mis_sum;
        cmp_total_d = cmp_sum;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mis_total_q <= '0;
      cmp_total_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mis_total_q <= mis_total_d;
      cmp_total_q <= cmp_total_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    mis_out_q <= mis_out_d;
    cmp_out_q <= cmp_out_d;
  end

  assign out_valid_o      = out_valid_q;
  assign mismatch_count_o = mis_out_q;
  assign compared_count_o = cmp_out_q;

endmodule

// ===== rtl/masked_packed_base_distance_core.sv =====
// a last word's totals appear on the output in the cycle after its transfer
// one word per cycle when not stalled; all lanes compare and one merge stage
//   popcounts and accumulates in the same cycle, output register decouples sides
// a new word is taken while a result is pending if the result leaves that cycle
// reset (async, active low) clears both running totals and the output valid
// top level: lanes of base compares feeding the merge and accumulate stage
module masked_packed_base_distance_core #(
  parameter int unsigned BASES_PER_WORD = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [mpbd_pkg::WORD_W-1:0]   word_a_i,
  input  logic [mpbd_pkg::WORD_W-1:0]   word_b_i,
  input  logic [mpbd_pkg::MASK_W-1:0]   include_mask_i,
  input  logic                          last_word_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [mpbd_pkg::TOTAL_W-1:0]  mismatch_count_o,
  output logic [mpbd_pkg::TOTAL_W-1:0]  compared_count_o
);

  mpbd_pkg::lane_flags_t [BASES_PER_WORD-1:0] flags;

  for (genvar k = 0; k < BASES_PER_WORD; k++) begin : g_lane
    mpbd_lane u_lane (
      .base_a_i  (word_a_i[mpbd_pkg::BASE_W*k +: mpbd_pkg::BASE_W]),
      .base_b_i  (word_b_i[mpbd_pkg::BASE_W*k +: mpbd_pkg::BASE_W]),
      .include_i (include_mask_i[k]),
      .flags_o   (flags[k])
    );
  end

  mpbd_merge #(
    .LANES (BASES_PER_WORD)
  ) u_merge (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .flags_i          (flags),
    .in_valid_i       (in_valid_i),
    .last_i           (last_word_i),
    .in_ready_o       (in_ready_o),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .mismatch_count_o (mismatch_count_o),
    .compared_count_o (compared_count_o)
  );

endmodule

// ===== rtl/mpbd_checker.sv =====
// port-level checks for the masked packed base distance core
module mpbd_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          last_word_i,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [mpbd_pkg::TOTAL_W-1:0]  mismatch_count_o,
  input logic [mpbd_pkg::TOTAL_W-1:0]  compared_count_o
);

  // stalled result stays
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      $stable(mismatch_count_o) && $stable(compared_count_o))
    else $error("result payload changed while stalled");

  // a mismatch is always an included position
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> mismatch_count_o <= compared_count_o)
    else $error("mismatch count above compared count");

  // a last word transfer yields a result in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && last_word_i |=> out_valid_o)
    else $error("no result after last word");

  // no new word while a result is blocked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken while output stalled");

endmodule

bind masked_packed_base_distance_core mpbd_checker u_mpbd_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_o       (in_ready_o),
  .last_word_i      (last_word_i),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .mismatch_count_o (mismatch_count_o),
  .compared_count_o (compared_count_o)
);
